FILE: sv/cdc_pkg.sv
package cdc_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned ColorWidthDef  = 8;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned AngW        = 34;
  localparam int unsigned FracW       = 17;
  localparam int unsigned ExpW        = 8;
  localparam int unsigned NormW       = 40;
  localparam int unsigned NumW        = 30;
  localparam int unsigned RangeW      = 16;
  localparam int unsigned LightXW     = NumW + 4;
  localparam int unsigned RotW        = 33;

  // pipeline depths of the three parts
  localparam int unsigned LightLat = 7 + CordicSteps;
  localparam int unsigned HueLat   = 6 + 2 * CordicSteps;
  localparam int unsigned HsbLat   = 4;
  localparam int unsigned TotalLat = HueLat + HsbLat;

  localparam logic [RangeW-1:0] RangeReset = 16'd256;

  // atan(2^-i) in binary angle units, one turn is 2^32
  localparam logic [29:0] AtanTurns [CordicSteps] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [AngW-1:0] HalfTurnS   = 34'sd2147483648;
  localparam logic [31:0]            HalfTurn    = 32'h8000_0000;
  localparam logic [29:0]            SineStart   = 30'd652032874;
  localparam logic [29:0]            HueCorrCoef = 30'd546852220;
  localparam logic [FracW-1:0]       FracOne     = 17'h10000;
  localparam logic [FracW-1:0]       FracHalf    = 17'h08000;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

endpackage

FILE: sv/cdc_delay.sv
module cdc_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

FILE: sv/cdc_vec_cordic.sv
module cdc_vec_cordic
  import cdc_pkg::*;
#(
  parameter int unsigned XW = LightXW
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [XW-1:0]   x_i,
  input  logic signed [XW-1:0]   y_i,
  input  logic signed [AngW-1:0] ang_i,
  output logic signed [AngW-1:0] ang_o
);

  logic signed [XW-1:0]   x_q [CordicSteps];
  logic signed [XW-1:0]   y_q [CordicSteps];
  logic signed [AngW-1:0] a_q [CordicSteps];

  for (genvar k = 0; k < CordicSteps; k++) begin : g_step
    logic signed [XW-1:0]   xc, yc, dx, dy;
    logic signed [AngW-1:0] ac, step;
    if (k == 0) begin : g_first
      assign xc = x_i;
      assign yc = y_i;
      assign ac = ang_i;
    end else begin : g_next
      assign xc = x_q[k-1];
      assign yc = y_q[k-1];
      assign ac = a_q[k-1];
    end
    assign dx   = yc >>> k;
    assign dy   = xc >>> k;
    assign step = $signed(AngW'(AtanTurns[k]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yc > 0) begin
          x_q[k] <= xc + dx;
          y_q[k] <= yc - dy;
          a_q[k] <= ac + step;
        end else begin
          x_q[k] <= xc - dx;
          y_q[k] <= yc + dy;
          a_q[k] <= ac - step;
        end
      end
    end
  end

  assign ang_o = a_q[CordicSteps-1];

endmodule

FILE: sv/cdc_rot_cordic.sv
module cdc_rot_cordic
  import cdc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AngW-1:0] z_i,
  output logic signed [RotW-1:0] sin_o
);

  logic signed [RotW-1:0] x_q [CordicSteps];
  logic signed [RotW-1:0] y_q [CordicSteps];
  logic signed [AngW-1:0] z_q [CordicSteps];

  for (genvar k = 0; k < CordicSteps; k++) begin : g_step
    logic signed [RotW-1:0] xc, yc, dx, dy;
    logic signed [AngW-1:0] zc, step;
    if (k == 0) begin : g_first
      assign xc = $signed(RotW'(SineStart));
      assign yc = '0;
      assign zc = z_i;
    end else begin : g_next
      assign xc = x_q[k-1];
      assign yc = y_q[k-1];
      assign zc = z_q[k-1];
    end
    assign dx   = yc >>> k;
    assign dy   = xc >>> k;
    assign step = $signed(AngW'(AtanTurns[k]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (zc >= 0) begin
          x_q[k] <= xc - dx;
          y_q[k] <= yc + dy;
          z_q[k] <= zc - step;
        end else begin
          x_q[k] <= xc + dx;
          y_q[k] <= yc - dy;
          z_q[k] <= zc + step;
        end
      end
    end
  end

  assign sin_o = y_q[CordicSteps-1];

endmodule

FILE: sv/cdc_light.sv
module cdc_light
  import cdc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] im_i,
  input  logic [RangeW-1:0]              inv_range_i,
  output logic [FracW-1:0]               light_o
);

  localparam int unsigned SqW   = 2 * SAMPLE_WIDTH;
  localparam int unsigned RXW   = (SqW > NormW) ? SqW : NormW;
  localparam int unsigned S1W   = $clog2(RXW + 1);
  localparam int unsigned ProdW = NormW + RangeW;
  localparam int unsigned BlW   = $clog2(ProdW + 1);
  localparam logic signed [ExpW-1:0] E0    = ExpW'(2 * (SAMPLE_WIDTH - 4) + 8);
  localparam logic signed [ExpW-1:0] NumWS = ExpW'(NumW);
  localparam logic [S1W-1:0]         NormS = S1W'(NormW);

  // squares
  logic [SqW-1:0] sq_re_q, sq_im_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_re_q <= SqW'(re_i * re_i);
      sq_im_q <= SqW'(im_i * im_i);
    end
  end

  // magnitude and first normalize amount
  logic [RXW-1:0] r_c;
  logic [S1W-1:0] bl1_c, s1_c;
  always_comb begin
    r_c   = RXW'(sq_re_q) + RXW'(sq_im_q);
    bl1_c = '0;
    for (int k = 0; k < RXW; k++) begin
      if (r_c[k]) bl1_c = S1W'(k + 1);
    end
    s1_c = (bl1_c > NormS) ? bl1_c - NormS : '0;
  end

  logic [RXW-1:0] r_q;
  logic [S1W-1:0] s1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q  <= r_c;
      s1_q <= s1_c;
    end
  end

  logic [NormW-1:0]       r1_q;
  logic signed [ExpW-1:0] e1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= NormW'(r_q >> s1_q);
      e1_q <= E0 - $signed(ExpW'(s1_q));
    end
  end

  // scale by the range register
  logic [ProdW-1:0]       num_q;
  logic signed [ExpW-1:0] e1b_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= ProdW'(r1_q) * ProdW'(inv_range_i);
      e1b_q <= e1_q;
    end
  end

  // second normalize amount
  logic [BlW-1:0]         bl2_c;
  logic signed [ExpW-1:0] over_bits_c, over_exp_c, s2_c;
  always_comb begin
    bl2_c = '0;
    for (int k = 0; k < ProdW; k++) begin
      if (num_q[k]) bl2_c = BlW'(k + 1);
    end
    over_bits_c = $signed(ExpW'(bl2_c)) - NumWS;
    over_exp_c  = e1b_q - (NumWS - 8'sd1);
    s2_c        = (over_bits_c > over_exp_c) ? over_bits_c : over_exp_c;
    if (s2_c < 0) s2_c = '0;
  end

  logic [ProdW-1:0]       num2_q;
  logic signed [ExpW-1:0] s2_q, e1c_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num2_q <= num_q;
      s2_q   <= s2_c;
      e1c_q  <= e1b_q;
    end
  end

  logic [NumW-1:0]        num3_c;
  logic signed [ExpW-1:0] e2_c;
  always_comb begin
    num3_c = NumW'(num2_q >> s2_q[ExpW-2:0]);
    e2_c   = e1c_q - s2_q;
  end

  logic signed [LightXW-1:0] x0_q, y0_q;
  logic [1:0]                flag_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q   <= (e2_c < 0) ? '0 : $signed(LightXW'(1) << e2_c[4:0]);
      y0_q   <= $signed(LightXW'(num3_c));
      flag_q <= {num3_c == '0, e2_c < 0};
    end
  end

  logic signed [AngW-1:0] ang_w;
  logic [1:0]             flag_w;

  cdc_vec_cordic #(.XW(LightXW)) u_cordic (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (x0_q),
    .y_i   (y0_q),
    .ang_i ('0),
    .ang_o (ang_w)
  );

  cdc_delay #(.W(2), .DEPTH(CordicSteps)) u_flag_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (flag_q),
    .q_o   (flag_w)
  );

  logic [FracW-1:0] light_q;
  logic [AngW-15:0] scaled_c;
  assign scaled_c = ang_w[AngW-1:14];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (flag_w[1]) begin
        light_q <= '0;
      end else if (flag_w[0]) begin
        light_q <= FracOne;
      end else if (ang_w < 0) begin
        light_q <= '0;
      end else if (scaled_c > (AngW-14)'(FracOne)) begin
        light_q <= FracOne;
      end else begin
        light_q <= FracW'(scaled_c);
      end
    end
  end

  assign light_o = light_q;

endmodule

FILE: sv/cdc_hue.sv
module cdc_hue
  import cdc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] im_i,
  output sector_e                        sector_o,
  output logic [15:0]                    frac_o
);

  localparam int unsigned HXW = SAMPLE_WIDTH + 3;

  // fold into the right half plane
  logic signed [HXW-1:0]  xs_c, ys_c;
  logic signed [HXW-1:0]  x0_q, y0_q;
  logic signed [AngW-1:0] a0_q;
  logic                   zero_q;
  assign xs_c = HXW'(re_i);
  assign ys_c = HXW'(im_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= (re_i == '0) && (im_i == '0);
      if (xs_c < 0) begin
        if (ys_c >= 0) begin
          x0_q <= ys_c;
          y0_q <= -xs_c;
          a0_q <= QuarterTurn;
        end else begin
          x0_q <= -ys_c;
          y0_q <= xs_c;
          a0_q <= -QuarterTurn;
        end
      end else begin
        x0_q <= xs_c;
        y0_q <= ys_c;
        a0_q <= '0;
      end
    end
  end

  logic signed [AngW-1:0] ang_w;
  logic                   zero_w;

  cdc_vec_cordic #(.XW(HXW)) u_angle (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (x0_q),
    .y_i   (y0_q),
    .ang_i (a0_q),
    .ang_o (ang_w)
  );

  cdc_delay #(.W(1), .DEPTH(CordicSteps)) u_zero_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (zero_q),
    .q_o   (zero_w)
  );

  // phase and triple phase
  logic [31:0] phi_c, phi_q, a3_q;
  assign phi_c = zero_w ? HalfTurn : ang_w[31:0] + HalfTurn;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q <= phi_c;
      a3_q  <= phi_c + {phi_c[30:0], 1'b0};
    end
  end

  // fold into -quarter..quarter turn
  logic signed [AngW-1:0] z_c, z_q;
  assign z_c = $signed(AngW'($signed(a3_q)));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_c > QuarterTurn) begin
        z_q <= HalfTurnS - z_c;
      end else if (z_c < -QuarterTurn) begin
        z_q <= -HalfTurnS - z_c;
      end else begin
        z_q <= z_c;
      end
    end
  end

  logic signed [RotW-1:0] sin_w;

  cdc_rot_cordic u_sine (
    .clk_i (clk_i),
    .en_i  (en_i),
    .z_i   (z_q),
    .sin_o (sin_w)
  );

  logic [31:0] phi_w;

  cdc_delay #(.W(32), .DEPTH(CordicSteps + 2)) u_phi_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (phi_q),
    .q_o   (phi_w)
  );

  // banding correction
  logic signed [63:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(sin_w * $signed({1'b0, HueCorrCoef}));
    end
  end

  logic [31:0] hue_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q <= phi_w + prod_q[63:32];
    end
  end

  // six sectors
  logic [34:0] h6_c;
  sector_e     sector_q;
  logic [15:0] frac_q;
  assign h6_c = ({3'b0, hue_q} << 2) + ({3'b0, hue_q} << 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_e'(h6_c[34:32]);
      frac_q   <= h6_c[31:16];
    end
  end

  assign sector_o = sector_q;
  assign frac_o   = frac_q;

endmodule

FILE: sv/cdc_hsb.sv
module cdc_hsb
  import cdc_pkg::*;
#(
  parameter int unsigned COLOR_WIDTH = ColorWidthDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [FracW-1:0]       light_i,
  input  sector_e                sector_i,
  input  logic [15:0]            frac_i,
  output logic [COLOR_WIDTH-1:0] red_o,
  output logic [COLOR_WIDTH-1:0] green_o,
  output logic [COLOR_WIDTH-1:0] blue_o
);

  localparam int unsigned AccW = FracW + COLOR_WIDTH + 1;
  localparam logic [COLOR_WIDTH-1:0] MaxV = '1;

  function automatic logic [COLOR_WIDTH-1:0] to_chan(input logic [FracW-1:0] v);
    logic [AccW-1:0]        acc;
    logic [COLOR_WIDTH+1:0] c;
    acc = AccW'(v) * AccW'(MaxV) + AccW'(FracHalf);
    c   = (COLOR_WIDTH+2)'(acc >> 16);
    return (c > (COLOR_WIDTH+2)'(MaxV)) ? MaxV : COLOR_WIDTH'(c);
  endfunction

  // saturation and brightness
  logic [FracW-1:0] sat_c, bri_c, inv_f_c;
  always_comb begin
    if (light_i < FracHalf) begin
      sat_c = FracOne;
      bri_c = {light_i[FracW-2:0], 1'b0};
    end else begin
      bri_c = FracOne;
      sat_c = FracW'(({1'b0, FracOne} << 1) - ({1'b0, light_i} << 1));
    end
    inv_f_c = FracOne - FracW'(frac_i);
  end

  logic [FracW-1:0] bri1_q, sat1_q, sf_q, sfn_q;
  sector_e          sec1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bri1_q <= bri_c;
      sat1_q <= sat_c;
      sf_q   <= FracW'(((2*FracW)'(sat_c) * (2*FracW)'(frac_i)) >> 16);
      sfn_q  <= FracW'(((2*FracW)'(sat_c) * (2*FracW)'(inv_f_c)) >> 16);
      sec1_q <= sector_i;
    end
  end

  logic [FracW-1:0] p_q, q_q, t_q, bri2_q;
  logic             gray_q;
  sector_e          sec2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= FracW'(((2*FracW)'(bri1_q) * (2*FracW)'(FracOne - sat1_q)) >> 16);
      q_q    <= FracW'(((2*FracW)'(bri1_q) * (2*FracW)'(FracOne - sf_q)) >> 16);
      t_q    <= FracW'(((2*FracW)'(bri1_q) * (2*FracW)'(FracOne - sfn_q)) >> 16);
      bri2_q <= bri1_q;
      gray_q <= (sat1_q == '0);
      sec2_q <= sec1_q;
    end
  end

  logic [FracW-1:0] rr_q, gg_q, bb_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (gray_q) begin
        rr_q <= bri2_q;
        gg_q <= bri2_q;
        bb_q <= bri2_q;
      end else begin
        case (sec2_q)
          SecRed: begin
            rr_q <= bri2_q; gg_q <= t_q; bb_q <= p_q;
          end
          SecYellow: begin
            rr_q <= q_q; gg_q <= bri2_q; bb_q <= p_q;
          end
          SecGreen: begin
            rr_q <= p_q; gg_q <= bri2_q; bb_q <= t_q;
          end
          SecCyan: begin
            rr_q <= p_q; gg_q <= q_q; bb_q <= bri2_q;
          end
          SecBlue: begin
            rr_q <= t_q; gg_q <= p_q; bb_q <= bri2_q;
          end
          default: begin
            rr_q <= bri2_q; gg_q <= p_q; bb_q <= q_q;
          end
        endcase
      end
    end
  end

  logic [COLOR_WIDTH-1:0] red_q, green_q, blue_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= to_chan(rr_q);
      green_q <= to_chan(gg_q);
      blue_q  <= to_chan(bb_q);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

FILE: sv/complex_domain_color_core.sv
// Complex sample to RGB pixel, domain coloring. One beat in per clock unless stalled, one pixel
// out per beat. Two 24-step CORDIC pipelines (sample angle, then sine of three times that angle
// for the hue banding) in series set the depth, while the lightness path (squared magnitude,
// range scaling, arctangent CORDIC) runs alongside. The whole pipeline advances together and
// holds while a result waits on out_ready_i. The range register may be rewritten only while no
// beat is in flight.
module complex_domain_color_core
  import cdc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned COLOR_WIDTH  = ColorWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [RangeW-1:0]              cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_part_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COLOR_WIDTH-1:0]         red_o,
  output logic [COLOR_WIDTH-1:0]         green_o,
  output logic [COLOR_WIDTH-1:0]         blue_o
);

  logic                adv;
  logic [TotalLat-1:0] valid_q;
  logic [RangeW-1:0]   inv_range_q;

  assign out_valid_o = valid_q[TotalLat-1];
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      inv_range_q <= RangeReset;
    end else begin
      if (adv) begin
        valid_q <= {valid_q[TotalLat-2:0], in_valid_i};
      end
      if (cfg_valid_i) begin
        inv_range_q <= cfg_data_i;
      end
    end
  end

  logic [FracW-1:0] light_w, light_al;
  sector_e          sector_w;
  logic [15:0]      frac_w;

  cdc_light #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_light (
    .clk_i       (clk_i),
    .en_i        (adv),
    .re_i        (real_part_i),
    .im_i        (imag_part_i),
    .inv_range_i (inv_range_q),
    .light_o     (light_w)
  );

  cdc_delay #(.W(FracW), .DEPTH(HueLat - LightLat)) u_light_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (light_w),
    .q_o   (light_al)
  );

  cdc_hue #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_hue (
    .clk_i    (clk_i),
    .en_i     (adv),
    .re_i     (real_part_i),
    .im_i     (imag_part_i),
    .sector_o (sector_w),
    .frac_o   (frac_w)
  );

  cdc_hsb #(.COLOR_WIDTH(COLOR_WIDTH)) u_hsb (
    .clk_i    (clk_i),
    .en_i     (adv),
    .light_i  (light_al),
    .sector_i (sector_w),
    .frac_i   (frac_w),
    .red_o    (red_o),
    .green_o  (green_o),
    .blue_o   (blue_o)
  );

endmodule
